>>> rtl/chm_pkg.sv
// shared types and constants for the chained hash map
package chm_pkg;

    localparam int KEY_W = 31;
    localparam int VAL_W = 32;
    localparam int MODE_W = 2;
    localparam int LG_W = 4;

    // request mode codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE = 2'd2;

    // value returned by a lookup miss
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'h8000_0000;

    // status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic found;
        logic signed [VAL_W-1:0] read_value;
        logic status;
    } rsp_t;

    // operation after classification
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        op_t op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } item_t;

endpackage

>>> rtl/chm_front.sv
// request intake, classification and two-deep request queue
module chm_front
    import chm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  req_t  request,
    output logic  busy,
    input  logic  pop,
    output logic  q_valid,
    output item_t q_item
);

    item_t slot_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] fill_reg;
    item_t cls;
    logic push;
    logic do_pop;

    // classify the incoming request
    always_comb
    begin
        cls.key = request.key;
        cls.value = request.value;
        case (request.mode)
            MODE_LOOKUP: cls.op = OP_LOOKUP;
            MODE_INSERT: cls.op = OP_INSERT;
            MODE_ERASE: cls.op = OP_ERASE;
            default: cls.op = OP_NONE;
        endcase
    end

    assign busy = (fill_reg == 2'd2);
    assign push = start && !busy;
    assign q_valid = (fill_reg != 2'd0);
    assign do_pop = pop && q_valid;
    assign q_item = slot_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(do_pop);
        end
    end

endmodule

>>> rtl/chm_back.sv
// chain walker, entry allocator and bucket-by-bucket rehash engine
module chm_back
    import chm_pkg::*;
#(
    parameter int INITIAL_BUCKETS = 8,
    parameter int MAX_BUCKETS = 256,
    parameter int POOL_ENTRIES = 512,
    parameter int LOAD_FACTOR = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  pop,
    output logic  done,
    output rsp_t  result
);

    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int IW = $clog2(POOL_ENTRIES);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(POOL_ENTRIES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
    localparam logic [CW-1:0] POOL_C = CW'(POOL_ENTRIES);
    localparam logic [LG_W-1:0] LG_INIT = LG_W'($clog2(INITIAL_BUCKETS + 1) - 1);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_HEAD    = 14'b00000000000010,
        S_WALK    = 14'b00000000000100,
        S_CHK     = 14'b00000000001000,
        S_ACT     = 14'b00000000010000,
        S_POP     = 14'b00000000100000,
        S_LINK    = 14'b00000001000000,
        S_TAIL    = 14'b00000010000000,
        S_RH_HEAD = 14'b00000100000000,
        S_RH_H2   = 14'b00001000000000,
        S_RH_WALK = 14'b00010000000000,
        S_RH_CHK  = 14'b00100000000000,
        S_RH_FIN1 = 14'b01000000000000,
        S_RH_FIN2 = 14'b10000000000000
    } state_t;

    // memories
    logic [LW-1:0] heads_mem [MAX_BUCKETS];
    logic [KEY_W-1:0] keys_mem [POOL_ENTRIES];
    logic [VAL_W-1:0] vals_mem [POOL_ENTRIES];
    logic [LW-1:0] links_mem [POOL_ENTRIES];
    logic [IW-1:0] stack_mem [POOL_ENTRIES];
    logic [MAX_BUCKETS-1:0] heads_vld_reg;

    logic [LW-1:0] heads_rd;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic [LW-1:0] rd_link;
    logic [IW-1:0] stack_rd;

    // memory port controls
    logic heads_we;
    logic [BW-1:0] heads_waddr;
    logic [LW-1:0] heads_wdata;
    logic [BW-1:0] heads_raddr;
    logic ent_we;
    logic [IW-1:0] ent_waddr;
    logic vals_we;
    logic [IW-1:0] vals_waddr;
    logic links_we;
    logic [IW-1:0] links_waddr;
    logic [LW-1:0] links_wdata;
    logic [IW-1:0] ent_raddr;
    logic stack_we;
    logic [IW-1:0] stack_raddr;

    // state
    state_t state_reg, state_next;
    op_t op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [LW-1:0] hitlink_reg, hitlink_next;
    logic [VAL_W-1:0] hitval_reg, hitval_next;
    logic found_reg, found_next;
    logic [IW-1:0] ent_reg, ent_next;
    logic [CW-1:0] hw_reg, hw_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [LG_W-1:0] lg_reg, lg_next;
    logic [BW-1:0] ri_reg, ri_next;
    logic [LW-1:0] lo_head_reg, lo_head_next;
    logic [LW-1:0] lo_tail_reg, lo_tail_next;
    logic [LW-1:0] hi_head_reg, hi_head_next;
    logic [LW-1:0] hi_tail_reg, hi_tail_next;
    logic done_reg, done_next;
    rsp_t res_reg, res_next;

    logic [KEY_W-1:0] key_mask;
    logic [KEY_W-1:0] low_bits;
    logic [BW-1:0] q_bkt;
    logic [BW-1:0] half_n;
    logic hi_side;
    logic pool_full;
    logic grow;

    // bucket of the queued key, clamped to the top bucket
    always_comb
    begin
        key_mask = (KEY_W'(1) << lg_reg) - KEY_W'(1);
        low_bits = q_item.key & key_mask;
        if (low_bits > KEY_W'(MAX_BUCKETS - 1))
        begin
            q_bkt = BW'(MAX_BUCKETS - 1);
        end
        else
        begin
            q_bkt = low_bits[BW-1:0];
        end
    end

    assign half_n = BW'(1) << lg_reg;
    assign hi_side = |(rd_key & (KEY_W'(1) << lg_reg));
    assign pool_full = (sp_reg == '0) && (hw_reg == POOL_C);
    assign grow = (32'(cnt_next) >= (32'(LOAD_FACTOR) << lg_reg))
               && ((32'(1) << lg_reg) < 32'(MAX_BUCKETS));

    // main sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        val_next = val_reg;
        bkt_next = bkt_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        hitlink_next = hitlink_reg;
        hitval_next = hitval_reg;
        found_next = found_reg;
        ent_next = ent_reg;
        hw_next = hw_reg;
        sp_next = sp_reg;
        cnt_next = cnt_reg;
        lg_next = lg_reg;
        ri_next = ri_reg;
        lo_head_next = lo_head_reg;
        lo_tail_next = lo_tail_reg;
        hi_head_next = hi_head_reg;
        hi_tail_next = hi_tail_reg;
        done_next = 1'b0;
        res_next = res_reg;
        pop = 1'b0;
        heads_we = 1'b0;
        heads_waddr = bkt_reg;
        heads_wdata = NIL;
        heads_raddr = q_bkt;
        ent_we = 1'b0;
        ent_waddr = ent_reg;
        vals_we = 1'b0;
        vals_waddr = ent_reg;
        links_we = 1'b0;
        links_waddr = ent_reg;
        links_wdata = NIL;
        ent_raddr = cur_reg[IW-1:0];
        stack_we = 1'b0;
        stack_raddr = IW'(sp_reg - CW'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    op_next = q_item.op;
                    key_next = q_item.key;
                    val_next = q_item.value;
                    bkt_next = q_bkt;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cur_next = heads_vld_reg[bkt_reg] ? heads_rd : NIL;
                prev_next = NIL;
                found_next = 1'b0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                state_next = (cur_reg == NIL) ? S_ACT : S_CHK;
            end
            S_CHK:
            begin
                if (rd_key == key_reg)
                begin
                    found_next = 1'b1;
                    ent_next = cur_reg[IW-1:0];
                    hitlink_next = rd_link;
                    hitval_next = rd_val;
                    state_next = S_ACT;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next = rd_link;
                    state_next = S_WALK;
                end
            end
            S_ACT:
            begin
                res_next.found = found_reg;
                res_next.read_value = '0;
                res_next.status = STATUS_DONE;
                state_next = S_IDLE;
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        res_next.read_value = found_reg ? hitval_reg : MISS_VALUE;
                        done_next = 1'b1;
                    end
                    OP_INSERT:
                    begin
                        if (found_reg)
                        begin
                            vals_we = 1'b1;
                            done_next = 1'b1;
                        end
                        else if (pool_full)
                        begin
                            res_next.status = STATUS_FULL;
                            done_next = 1'b1;
                        end
                        else if (hw_reg != POOL_C)
                        begin
                            ent_next = hw_reg[IW-1:0];
                            hw_next = hw_reg + CW'(1);
                            state_next = S_LINK;
                        end
                        else
                        begin
                            sp_next = sp_reg - CW'(1);
                            state_next = S_POP;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (found_reg)
                        begin
                            // unlink the hit and return it to the free stack
                            if (prev_reg == NIL)
                            begin
                                heads_we = 1'b1;
                                heads_wdata = hitlink_reg;
                            end
                            else
                            begin
                                links_we = 1'b1;
                                links_waddr = prev_reg[IW-1:0];
                                links_wdata = hitlink_reg;
                            end
                            stack_we = 1'b1;
                            sp_next = sp_reg + CW'(1);
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        done_next = 1'b1;
                    end
                    default:
                    begin
                        res_next.found = 1'b0;
                        done_next = 1'b1;
                    end
                endcase
            end
            S_POP:
            begin
                ent_next = stack_rd;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                ent_we = 1'b1;
                vals_we = 1'b1;
                links_we = 1'b1;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                // hook the new entry at the chain tail
                if (prev_reg == NIL)
                begin
                    heads_we = 1'b1;
                    heads_wdata = {1'b0, ent_reg};
                end
                else
                begin
                    links_we = 1'b1;
                    links_waddr = prev_reg[IW-1:0];
                    links_wdata = {1'b0, ent_reg};
                end
                cnt_next = cnt_reg + CW'(1);
                done_next = 1'b1;
                ri_next = '0;
                state_next = grow ? S_RH_HEAD : S_IDLE;
            end
            S_RH_HEAD:
            begin
                heads_raddr = ri_reg;
                state_next = S_RH_H2;
            end
            S_RH_H2:
            begin
                cur_next = heads_vld_reg[ri_reg] ? heads_rd : NIL;
                lo_head_next = NIL;
                lo_tail_next = NIL;
                hi_head_next = NIL;
                hi_tail_next = NIL;
                state_next = S_RH_WALK;
            end
            S_RH_WALK:
            begin
                state_next = (cur_reg == NIL) ? S_RH_FIN1 : S_RH_CHK;
            end
            S_RH_CHK:
            begin
                // split the chain into low and high halves in order
                links_wdata = cur_reg;
                if (hi_side)
                begin
                    if (hi_tail_reg == NIL)
                    begin
                        hi_head_next = cur_reg;
                    end
                    else
                    begin
                        links_we = 1'b1;
                        links_waddr = hi_tail_reg[IW-1:0];
                    end
                    hi_tail_next = cur_reg;
                end
                else
                begin
                    if (lo_tail_reg == NIL)
                    begin
                        lo_head_next = cur_reg;
                    end
                    else
                    begin
                        links_we = 1'b1;
                        links_waddr = lo_tail_reg[IW-1:0];
                    end
                    lo_tail_next = cur_reg;
                end
                cur_next = rd_link;
                state_next = S_RH_WALK;
            end
            S_RH_FIN1:
            begin
                links_we = (lo_tail_reg != NIL);
                links_waddr = lo_tail_reg[IW-1:0];
                heads_we = 1'b1;
                heads_waddr = ri_reg;
                heads_wdata = lo_head_reg;
                state_next = S_RH_FIN2;
            end
            S_RH_FIN2:
            begin
                links_we = (hi_tail_reg != NIL);
                links_waddr = hi_tail_reg[IW-1:0];
                heads_we = 1'b1;
                heads_waddr = ri_reg + half_n;
                heads_wdata = hi_head_reg;
                if (ri_reg == half_n - BW'(1))
                begin
                    lg_next = lg_reg + LG_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    ri_next = ri_reg + BW'(1);
                    state_next = S_RH_HEAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // bucket head memory
    always_ff @(posedge clk)
    begin
        if (heads_we)
        begin
            heads_mem[heads_waddr] <= heads_wdata;
        end
        heads_rd <= heads_mem[heads_raddr];
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            keys_mem[ent_waddr] <= key_reg;
        end
        if (vals_we)
        begin
            vals_mem[vals_waddr] <= val_reg;
        end
        if (links_we)
        begin
            links_mem[links_waddr] <= links_wdata;
        end
        rd_key <= keys_mem[ent_raddr];
        rd_val <= vals_mem[ent_raddr];
        rd_link <= links_mem[ent_raddr];
    end

    // free entry stack
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[sp_reg[IW-1:0]] <= ent_reg;
        end
        stack_rd <= stack_mem[stack_raddr];
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_NONE;
            key_reg <= '0;
            val_reg <= '0;
            bkt_reg <= '0;
            cur_reg <= NIL;
            prev_reg <= NIL;
            hitlink_reg <= NIL;
            hitval_reg <= '0;
            found_reg <= 1'b0;
            ent_reg <= '0;
            hw_reg <= '0;
            sp_reg <= '0;
            cnt_reg <= '0;
            lg_reg <= LG_INIT;
            ri_reg <= '0;
            lo_head_reg <= NIL;
            lo_tail_reg <= NIL;
            hi_head_reg <= NIL;
            hi_tail_reg <= NIL;
            done_reg <= 1'b0;
            res_reg <= '0;
            heads_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            key_reg <= key_next;
            val_reg <= val_next;
            bkt_reg <= bkt_next;
            cur_reg <= cur_next;
            prev_reg <= prev_next;
            hitlink_reg <= hitlink_next;
            hitval_reg <= hitval_next;
            found_reg <= found_next;
            ent_reg <= ent_next;
            hw_reg <= hw_next;
            sp_reg <= sp_next;
            cnt_reg <= cnt_next;
            lg_reg <= lg_next;
            ri_reg <= ri_next;
            lo_head_reg <= lo_head_next;
            lo_tail_reg <= lo_tail_next;
            hi_head_reg <= hi_head_next;
            hi_tail_reg <= hi_tail_next;
            done_reg <= done_next;
            res_reg <= res_next;
            if (heads_we)
            begin
                heads_vld_reg[heads_waddr] <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign result = res_reg;

    // a dropped insert never reports a hit
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (res_reg.status == STATUS_FULL) |-> !res_reg.found)
        else $error("full status with found set");

    // between requests, live entries equal allocated minus freed
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cnt_reg == hw_reg - sp_reg))
        else $error("entry count out of step with allocator");

    // high-water mark never passes the pool size
    a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= POOL_C)
        else $error("allocator past pool end");

    // bucket count only grows at the end of a rehash pass
    a_lg_step: assert property (@(posedge clk) disable iff (!rst_n)
        (lg_reg != $past(lg_reg)) |-> ($past(state_reg) == S_RH_FIN2))
        else $error("bucket count changed outside rehash");

endmodule

>>> rtl/chained_hash_map_top.sv
// top level of the chained hash map
//
// channel   direction  handshake            payload
// request   in         start && !busy       request (mode, key, value)
// result    out        done, one cycle      result (found, read_value, status)
//
// a request walks its bucket chain entry by entry; a new-key
// insert then allocates an entry and links it at the chain tail
// a rehash after an insert splits each old bucket's chain in turn
// reset empties the table at once through per-bucket valid bits; no clearing pass
// a two-deep queue takes requests while the chain walker works; busy is high
// when it is full, and results are never held back
module chained_hash_map_top
    import chm_pkg::*;
#(
    parameter int INITIAL_BUCKETS = 8,
    parameter int MAX_BUCKETS = 256,
    parameter int POOL_ENTRIES = 512,
    parameter int LOAD_FACTOR = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    logic q_valid;
    item_t q_item;
    logic pop;

    // intake queue
    chm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    // table engine
    chm_back #(
        .INITIAL_BUCKETS (INITIAL_BUCKETS),
        .MAX_BUCKETS     (MAX_BUCKETS),
        .POOL_ENTRIES    (POOL_ENTRIES),
        .LOAD_FACTOR     (LOAD_FACTOR)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule
